### sv/text_terminal_screen_buffer_defines.svh
// ----------------------------------------------------------------------------
// text_terminal_screen_buffer_defines
// assertion macros used by the checker file tts_chk
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCREEN_BUFFER_DEFINES_SVH
`define TEXT_TERMINAL_SCREEN_BUFFER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TTS_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define TTS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// shared types and constants of the character terminal screen buffer
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam int ROW_COUNT_DEF = 24;
	localparam int COL_COUNT_DEF = 40;

	localparam int ACT_W  = 2;
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 6;
	localparam int CHAR_W = 7;

	// stream payload layout
	localparam int IN_FIELDS_W  = ACT_W + BYTE_W + ROW_W + COL_W;
	localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = CHAR_W + ROW_W + COL_W + 1;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int IN_BYTE_LSB  = ACT_W;
	localparam int IN_ROW_LSB   = IN_BYTE_LSB + BYTE_W;
	localparam int IN_COL_LSB   = IN_ROW_LSB + ROW_W;
	localparam int OUT_ROW_LSB  = CHAR_W;
	localparam int OUT_COL_LSB  = OUT_ROW_LSB + ROW_W;
	localparam int OUT_SCR_BIT  = OUT_COL_LSB + COL_W;

	// byte codes
	localparam logic [BYTE_W-1:0] BYTE_BACK  = 8'h5F;
	localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_FIRST = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_LAST  = 8'h7E;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CHAR_MARK  = 7'h5F;

	// blink phase runs 0, 1, 2
	localparam logic [1:0] PHASE_LAST = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUT  = 2'd0,
		ACT_TICK = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_MARK,
		ST_RDATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              scrolled;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [CHAR_W-1:0] cell_char;
	} res_t;

endpackage

`default_nettype wire

### sv/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// sequencer: cursor, scroll base, blink phase and screen ram accesses
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl #(
	parameter int ROW_COUNT = tts_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = tts_pkg::COL_COUNT_DEF,
	localparam int CELLS  = ROW_COUNT * COL_COUNT,
	localparam int ADDR_W = $clog2(CELLS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [tts_pkg::IN_W-1:0]  s_tdata,
	output logic                           res_load,
	output tts_pkg::res_t                  res,
	input  wire logic                      out_free,
	output logic                           mem_wr_en,
	output logic      [ADDR_W-1:0]         mem_wr_addr,
	output logic      [tts_pkg::CHAR_W-1:0] mem_wr_data,
	output logic                           mem_rd_en,
	output logic      [ADDR_W-1:0]         mem_rd_addr,
	input  wire logic [tts_pkg::CHAR_W-1:0] mem_rd_data
);

	localparam int RIDX_W = $clog2(ROW_COUNT);
	localparam int CIDX_W = $clog2(COL_COUNT);

	tts_pkg::state_t state_q, state_d;

	// item fields
	logic [tts_pkg::ACT_W-1:0]  act_q;
	logic [tts_pkg::BYTE_W-1:0] byte_q;
	logic [tts_pkg::ROW_W-1:0]  rrow_q;
	logic [tts_pkg::COL_W-1:0]  rcol_q;

	logic [RIDX_W-1:0] cur_row_q;
	logic [CIDX_W-1:0] cur_col_q;
	logic [RIDX_W-1:0] base_q;
	logic [1:0]        phase_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [CIDX_W-1:0] clr_cnt_q;

	logic [tts_pkg::CHAR_W-1:0] char_q;
	logic                       scr_q;
	logic                       inrange_q;

	// logical row to physical row through the scroll base
	logic [RIDX_W:0]   cur_sum, rd_sum;
	logic [RIDX_W-1:0] cur_phys, rd_phys;
	logic [ADDR_W-1:0] cur_addr, rd_addr;
	logic              rd_in_range;

	assign cur_sum  = {1'b0, cur_row_q} + {1'b0, base_q};
	assign cur_phys = (cur_sum >= (RIDX_W+1)'(ROW_COUNT))
		? RIDX_W'(cur_sum - (RIDX_W+1)'(ROW_COUNT)) : RIDX_W'(cur_sum);
	assign cur_addr = ADDR_W'(cur_phys * COL_COUNT) + ADDR_W'(cur_col_q);

	assign rd_in_range = (32'(rrow_q) < ROW_COUNT) && (32'(rcol_q) < COL_COUNT);
	assign rd_sum  = {1'b0, RIDX_W'(rrow_q)} + {1'b0, base_q};
	assign rd_phys = (rd_sum >= (RIDX_W+1)'(ROW_COUNT))
		? RIDX_W'(rd_sum - (RIDX_W+1)'(ROW_COUNT)) : RIDX_W'(rd_sum);
	assign rd_addr = ADDR_W'(rd_phys * COL_COUNT) + ADDR_W'(rcol_q);

	// put byte: cell write and next cursor
	logic [RIDX_W:0]            nr;
	logic [CIDX_W-1:0]          nc;
	logic                       put_we;
	logic [tts_pkg::CHAR_W-1:0] put_ch;
	logic                       put_scroll;

	always_comb begin
		nr     = {1'b0, cur_row_q};
		nc     = cur_col_q;
		put_we = 1'b0;
		put_ch = tts_pkg::CHAR_SPACE;
		priority if (byte_q == tts_pkg::BYTE_BACK) begin
			put_we = 1'b1;
			if (cur_col_q == '0) begin
				// top-left corner stays put
				if (cur_row_q != '0) begin
					nr = nr - 1'b1;
					nc = CIDX_W'(COL_COUNT - 1);
				end
			end else begin
				nc = cur_col_q - 1'b1;
			end
		end else if (byte_q == tts_pkg::BYTE_CR) begin
			put_we = 1'b1;
			nc     = '0;
			nr     = nr + 1'b1;
		end else if (byte_q >= tts_pkg::BYTE_FIRST && byte_q <= tts_pkg::BYTE_LAST) begin
			put_we = 1'b1;
			put_ch = byte_q[tts_pkg::CHAR_W-1:0];
			if ({1'b0, cur_col_q} == (CIDX_W+1)'(COL_COUNT - 1)) begin
				nc = '0;
				nr = nr + 1'b1;
			end else begin
				nc = cur_col_q + 1'b1;
			end
		end else begin
			// other bytes write no character and leave the cursor alone
			put_we = 1'b0;
		end
	end

	assign put_scroll = (nr >= (RIDX_W+1)'(ROW_COUNT));

	logic [1:0]                 ph_next;
	logic [tts_pkg::CHAR_W-1:0] tick_ch;

	assign ph_next = (phase_q == tts_pkg::PHASE_LAST) ? 2'd0 : phase_q + 2'd1;
	assign tick_ch = (ph_next == tts_pkg::PHASE_LAST) ? tts_pkg::CHAR_SPACE : tts_pkg::CHAR_MARK;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tts_pkg::ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(CELLS - 1)) state_d = tts_pkg::ST_IDLE;
			end
			tts_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = tts_pkg::ST_EXEC;
			end
			tts_pkg::ST_EXEC: begin
				if (act_q == tts_pkg::ACT_PUT) begin
					state_d = put_scroll ? tts_pkg::ST_SCROLL : tts_pkg::ST_MARK;
				end else if (act_q == tts_pkg::ACT_TICK) begin
					state_d = tts_pkg::ST_DONE;
				end else begin
					state_d = tts_pkg::ST_RDATA;
				end
			end
			tts_pkg::ST_SCROLL: begin
				if (clr_cnt_q == CIDX_W'(COL_COUNT - 1)) state_d = tts_pkg::ST_MARK;
			end
			tts_pkg::ST_MARK:  state_d = tts_pkg::ST_DONE;
			tts_pkg::ST_RDATA: state_d = tts_pkg::ST_DONE;
			tts_pkg::ST_DONE: begin
				if (out_free) state_d = tts_pkg::ST_IDLE;
			end
			default: state_d = tts_pkg::ST_CLEAR;
		endcase
	end

	// ram accesses and handshakes
	always_comb begin
		s_tready    = 1'b0;
		res_load    = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = cur_addr;
		mem_wr_data = tts_pkg::CHAR_SPACE;
		mem_rd_en   = 1'b0;
		mem_rd_addr = cur_addr;
		unique case (state_q)
			tts_pkg::ST_CLEAR, tts_pkg::ST_SCROLL: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_addr_q;
			end
			tts_pkg::ST_IDLE: s_tready = 1'b1;
			tts_pkg::ST_EXEC: begin
				unique case (act_q)
					tts_pkg::ACT_PUT: begin
						mem_wr_en   = put_we;
						mem_wr_data = put_ch;
					end
					tts_pkg::ACT_TICK: begin
						mem_wr_en   = 1'b1;
						mem_wr_data = tick_ch;
					end
					tts_pkg::ACT_READ: begin
						mem_rd_en   = rd_in_range;
						mem_rd_addr = rd_addr;
					end
					default: mem_rd_en = 1'b1;
				endcase
			end
			tts_pkg::ST_MARK: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = tts_pkg::CHAR_MARK;
			end
			tts_pkg::ST_RDATA: ;
			tts_pkg::ST_DONE: res_load = out_free;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tts_pkg::ST_CLEAR;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			base_q     <= '0;
			phase_q    <= '0;
			clr_addr_q <= '0;
			clr_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tts_pkg::ST_CLEAR, tts_pkg::ST_SCROLL: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					clr_cnt_q  <= clr_cnt_q + 1'b1;
				end
				tts_pkg::ST_EXEC: begin
					if (act_q == tts_pkg::ACT_PUT) begin
						cur_col_q <= nc;
						if (put_scroll) begin
							// old top row becomes the new bottom row
							cur_row_q  <= RIDX_W'(ROW_COUNT - 1);
							base_q     <= (base_q == RIDX_W'(ROW_COUNT - 1))
								? '0 : base_q + 1'b1;
							clr_addr_q <= ADDR_W'(base_q * COL_COUNT);
							clr_cnt_q  <= '0;
						end else begin
							cur_row_q <= RIDX_W'(nr);
						end
					end else if (act_q == tts_pkg::ACT_TICK) begin
						phase_q <= ph_next;
					end
				end
				default: ;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			tts_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					act_q  <= s_tdata[tts_pkg::ACT_W-1:0];
					byte_q <= s_tdata[tts_pkg::IN_BYTE_LSB +: tts_pkg::BYTE_W];
					rrow_q <= s_tdata[tts_pkg::IN_ROW_LSB +: tts_pkg::ROW_W];
					rcol_q <= s_tdata[tts_pkg::IN_COL_LSB +: tts_pkg::COL_W];
				end
			end
			tts_pkg::ST_EXEC: begin
				scr_q     <= (act_q == tts_pkg::ACT_PUT) && put_scroll;
				inrange_q <= (act_q == tts_pkg::ACT_READ) ? rd_in_range : 1'b1;
				char_q    <= tick_ch;
			end
			tts_pkg::ST_MARK:  char_q <= tts_pkg::CHAR_MARK;
			tts_pkg::ST_RDATA: char_q <= inrange_q ? mem_rd_data : tts_pkg::CHAR_SPACE;
			default: ;
		endcase
	end

	assign res.cell_char  = char_q;
	assign res.cursor_row = tts_pkg::ROW_W'(cur_row_q);
	assign res.cursor_col = tts_pkg::COL_W'(cur_col_q);
	assign res.scrolled   = scr_q;

endmodule

`default_nettype wire

### sv/tts_out.sv
// ----------------------------------------------------------------------------
// tts_out
// result holding register on the master side of the stream
// ----------------------------------------------------------------------------
`default_nettype none

module tts_out (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire tts_pkg::res_t             res,
	output logic                           free,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [tts_pkg::OUT_W-1:0] m_tdata
);

	logic          valid_q;
	tts_pkg::res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(tts_pkg::OUT_W - tts_pkg::OUT_FIELDS_W){1'b0}}, res_q};

endmodule

`default_nettype wire

### sv/text_terminal_screen_buffer.sv
// ----------------------------------------------------------------------------
// text_terminal_screen_buffer
// character terminal screen store with cursor, scroll and cursor blink
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   action, byte_value, read_row, read_col
//  m_*      out        m_tvalid/m_tready   cell_char, cursor_row, cursor_col, scrolled
//
// a tick passes the states exec and done, a put exec, mark and done, a read
// exec, rdata and done; a put that scrolls also clears the new bottom row in
// the scroll state (the screen rows rotate through a base register, so no
// row is copied). all work goes through one screen ram. after reset a
// clearing pass fills ROW_COUNT*COL_COUNT cells with spaces, one per cycle,
// with s_tready low. one item is in work at a time; a finished result waits
// in the output register while the next item is accepted, and stalls the
// block only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_screen_buffer #(
	parameter int ROW_COUNT = tts_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = tts_pkg::COL_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// action[1:0], byte_value[9:2], read_row[14:10], read_col[20:15], zero pad
	input  wire logic [tts_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// cell_char[6:0], cursor_row[11:7], cursor_col[17:12], scrolled[18], zero pad
	output logic      [tts_pkg::OUT_W-1:0]  m_tdata
);

	localparam int CELLS  = ROW_COUNT * COL_COUNT;
	localparam int ADDR_W = $clog2(CELLS);

	tts_pkg::res_t              res;
	logic                       res_load;
	logic                       out_free;
	logic                       mem_wr_en, mem_rd_en;
	logic [ADDR_W-1:0]          mem_wr_addr, mem_rd_addr;
	logic [tts_pkg::CHAR_W-1:0] mem_wr_data, mem_rd_data;

	tts_ctrl #(
		.ROW_COUNT (ROW_COUNT),
		.COL_COUNT (COL_COUNT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.res_load    (res_load),
		.res         (res),
		.out_free    (out_free),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	tts_ram #(
		.WIDTH (tts_pkg::CHAR_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	tts_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

### sv/tts_chk.sv
// ----------------------------------------------------------------------------
// tts_chk
// port level checks of the screen buffer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_terminal_screen_buffer_defines.svh"

module tts_chk #(
	parameter int ROW_COUNT = tts_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = tts_pkg::COL_COUNT_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [tts_pkg::OUT_W-1:0] m_tdata
);

	logic [tts_pkg::ROW_W-1:0] out_row;
	logic [tts_pkg::COL_W-1:0] out_col;
	logic                      out_scr;
	logic                      cursor_ok;
	logic                      bottom_row;

	assign out_row    = m_tdata[tts_pkg::OUT_ROW_LSB +: tts_pkg::ROW_W];
	assign out_col    = m_tdata[tts_pkg::OUT_COL_LSB +: tts_pkg::COL_W];
	assign out_scr    = m_tdata[tts_pkg::OUT_SCR_BIT];
	assign cursor_ok  = (32'(out_row) < ROW_COUNT) && (32'(out_col) < COL_COUNT);
	assign bottom_row = (32'(out_row) == ROW_COUNT - 1);

	// a stalled result holds
	`TTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// one item in work at a time
	`TTS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")

	// cursor stays on the screen
	`TTS_ASSERT_NOW(a_cursor_range, m_tvalid, cursor_ok, "cursor off screen")

	// a scroll leaves the cursor on the bottom row
	`TTS_ASSERT_NOW(a_scroll_row, m_tvalid && out_scr, bottom_row, "scroll left cursor off bottom row")

endmodule

bind text_terminal_screen_buffer tts_chk #(
	.ROW_COUNT (ROW_COUNT),
	.COL_COUNT (COL_COUNT)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
